// File: rtl/plob_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the price level order book.
// No dependencies.
package plob_pkg;

    localparam int PriceW  = 32;
    localparam int AmountW = 32;
    localparam int StatusW = 2;

    localparam logic [StatusW-1:0] StOk       = 2'd0;
    localparam logic [StatusW-1:0] StNotFound = 2'd1;
    localparam logic [StatusW-1:0] StFull     = 2'd2;

    typedef struct packed {
        logic               vld;
        logic [PriceW-1:0]  price;
        logic [AmountW-1:0] amount;
    } t_level;

    // per-cell compare results
    typedef struct packed {
        logic hit;    // cell holds the update price
        logic after;  // update price sorts before this cell (or cell empty)
    } t_cell_flags;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_TAKE_RIGHT,
        OP_TAKE_LEFT,
        OP_LOAD,
        OP_SET_AMT
    } t_cell_op;

endpackage

// File: rtl/plob_cell.sv
`timescale 1ns / 1ps
// One price level cell: holds a level, compares it against the update.
// Depends on plob_pkg.
module plob_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_ask,
    input  logic [plob_pkg::PriceW-1:0]  i_price,
    input  logic [plob_pkg::AmountW-1:0] i_amount,
    input  plob_pkg::t_cell_op           i_op,
    input  plob_pkg::t_level             i_left,
    input  plob_pkg::t_level             i_right,
    output plob_pkg::t_level             o_level,
    output plob_pkg::t_cell_flags        o_flags
);

    plob_pkg::t_level r_level;
    plob_pkg::t_level n_level;

    always_comb begin
        o_flags.hit   = r_level.vld && (r_level.price == i_price);
        o_flags.after = !r_level.vld ||
                        (i_ask ? (i_price < r_level.price) : (i_price > r_level.price));
    end

    always_comb begin
        n_level = r_level;
        case (i_op)
            plob_pkg::OP_TAKE_RIGHT: n_level = i_right;
            plob_pkg::OP_TAKE_LEFT:  n_level = i_left;
            plob_pkg::OP_LOAD:       n_level = '{vld: 1'b1, price: i_price, amount: i_amount};
            plob_pkg::OP_SET_AMT:    n_level.amount = i_amount;
            default:                 n_level = r_level;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_level.price  <= n_level.price;
        r_level.amount <= n_level.amount;
        if (!i_rst_n) begin
            r_level.vld <= 1'b0;
        end else begin
            r_level.vld <= n_level.vld;
        end
    end

    assign o_level = r_level;

endmodule

// File: rtl/plob_side.sv
`timescale 1ns / 1ps
// One side of the book: a sorted chain of level cells plus best/fill queries.
// Depends on plob_pkg and plob_cell.
module plob_side #(
    parameter int LEVELS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ask,
    input  logic                          i_upd,
    input  logic [plob_pkg::PriceW-1:0]   i_price,
    input  logic [plob_pkg::AmountW-1:0]  i_amount,
    input  logic [plob_pkg::AmountW-1:0]  i_min,
    output logic [plob_pkg::StatusW-1:0]  o_status,
    output plob_pkg::t_level              o_best,
    output logic                          o_fill_found,
    output logic [plob_pkg::PriceW-1:0]   o_fill_price
);

    plob_pkg::t_level      lvl   [LEVELS];
    plob_pkg::t_cell_flags flg   [LEVELS];
    plob_pkg::t_cell_op    op    [LEVELS];
    logic [LEVELS-1:0]     del_pre;
    logic [LEVELS:0]       f_found;
    logic [plob_pkg::PriceW-1:0] f_price [LEVELS+1];
    logic hit_any;
    logic full;
    logic zero_amt;

    assign full     = lvl[LEVELS-1].vld;
    assign zero_amt = (i_amount == '0);
    assign hit_any  = del_pre[LEVELS-1];

    genvar g;
    generate
        for (g = 0; g < LEVELS; g++) begin : g_cell
            plob_pkg::t_level left_l;
            plob_pkg::t_level right_l;
            logic             after_left;

            if (g == 0) begin : g_first
                assign left_l     = '0;
                assign after_left = 1'b0;
                assign del_pre[g] = flg[g].hit;
            end else begin : g_mid
                assign left_l     = lvl[g-1];
                assign after_left = flg[g-1].after;
                assign del_pre[g] = del_pre[g-1] | flg[g].hit;
            end
            if (g == LEVELS - 1) begin : g_last
                assign right_l = '0;
            end else begin : g_notlast
                assign right_l = lvl[g+1];
            end

            always_comb begin
                op[g] = plob_pkg::OP_HOLD;
                if (i_upd) begin
                    if (hit_any) begin
                        if (zero_amt) begin
                            if (del_pre[g]) op[g] = plob_pkg::OP_TAKE_RIGHT;
                        end else if (flg[g].hit) begin
                            op[g] = plob_pkg::OP_SET_AMT;
                        end
                    end else if (!zero_amt && !full && flg[g].after) begin
                        op[g] = after_left ? plob_pkg::OP_TAKE_LEFT : plob_pkg::OP_LOAD;
                    end
                end
            end

            plob_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ask    (i_ask),
                .i_price  (i_price),
                .i_amount (i_amount),
                .i_op     (op[g]),
                .i_left   (left_l),
                .i_right  (right_l),
                .o_level  (lvl[g]),
                .o_flags  (flg[g])
            );

            // fill query ripples from the worst level toward the best
            assign f_found[g] = (lvl[g].vld && lvl[g].amount >= i_min) ? 1'b1 : f_found[g+1];
            assign f_price[g] = (lvl[g].vld && lvl[g].amount >= i_min) ? lvl[g].price
                                                                       : f_price[g+1];
        end
    endgenerate

    assign f_found[LEVELS] = 1'b0;
    assign f_price[LEVELS] = '0;

    always_comb begin
        if (hit_any)       o_status = plob_pkg::StOk;
        else if (zero_amt) o_status = plob_pkg::StNotFound;
        else if (full)     o_status = plob_pkg::StFull;
        else               o_status = plob_pkg::StOk;
    end

    assign o_best       = lvl[0].vld ? lvl[0] : '0;
    assign o_fill_found = f_found[0];
    assign o_fill_price = f_price[0];

endmodule

// File: rtl/price_level_order_book.sv
`timescale 1ns / 1ps
// Top level of the price level order book: bid and ask cell chains, result register.
// Depends on plob_pkg and plob_side.
//
// channel | dir | handshake                 | payload
// s_axis  | in  | i_s_axis_tvalid/o_..tready | tdata {amount, price}, tuser side
// m_axis  | out | o_m_axis_tvalid/i_..tready | tdata result fields
// cfg     | in  | i_cfg_valid/o_cfg_ready    | i_cfg_data min_fill_amount
//
// An update shifts the cell chain at the edge it is accepted; the result
// register then captures best and fill levels from the shifted chain and
// offers them as the result. A new item is taken once that result has been
// taken. Reset empties both chains and sets min_fill_amount to 1. Output
// stall holds the result and blocks the input.
module price_level_order_book #(
    parameter int LEVELS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,   // price[31:0], amount[63:32]
    input  logic [0:0]   i_s_axis_tuser,   // side[0]
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // status[1:0], bid_valid[2], bid_price[34:3], bid_amount[66:35], ask_valid[67],
    // ask_price[99:68], ask_amount[131:100], fill_bid_found[132],
    // fill_bid_price[164:133], fill_ask_found[165], fill_ask_price[197:166], zeros
    output logic [199:0] o_m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [31:0]  i_cfg_data
);

    logic r_busy;
    logic r_out_vld;
    logic [plob_pkg::StatusW-1:0] r_status;
    logic [31:0] r_min;
    logic [199:0] r_out;
    logic [199:0] n_out;

    logic in_acc;
    logic [31:0] price, amount;
    logic side;

    logic [plob_pkg::StatusW-1:0] bid_st, ask_st;
    plob_pkg::t_level bid_best, ask_best;
    logic bid_ff, ask_ff;
    logic [31:0] bid_fp, ask_fp;

    assign o_s_axis_tready = !r_busy && !r_out_vld;
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign price  = i_s_axis_tdata[31:0];
    assign amount = i_s_axis_tdata[63:32];
    assign side   = i_s_axis_tuser[0];
    assign o_cfg_ready = 1'b1;

    plob_side #(.LEVELS(LEVELS)) u_bid (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ask(1'b0), .i_upd(in_acc && !side),
        .i_price(price), .i_amount(amount), .i_min(r_min),
        .o_status(bid_st), .o_best(bid_best),
        .o_fill_found(bid_ff), .o_fill_price(bid_fp)
    );

    plob_side #(.LEVELS(LEVELS)) u_ask (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ask(1'b1), .i_upd(in_acc && side),
        .i_price(price), .i_amount(amount), .i_min(r_min),
        .o_status(ask_st), .o_best(ask_best),
        .o_fill_found(ask_ff), .o_fill_price(ask_fp)
    );

    assign n_out = {2'b00, ask_fp, ask_ff, bid_fp, bid_ff,
                    ask_best.amount, ask_best.price, ask_best.vld,
                    bid_best.amount, bid_best.price, bid_best.vld, r_status};

    always_ff @(posedge i_clk) begin
        if (in_acc) r_status <= side ? ask_st : bid_st;
        if (r_busy) r_out <= n_out;
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
            r_min     <= 32'd1;
        end else begin
            if (i_cfg_valid) r_min <= i_cfg_data;
            r_busy <= in_acc;
            if (r_busy) r_out_vld <= 1'b1;
            else if (i_m_axis_tready) r_out_vld <= 1'b0;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

endmodule

// File: rtl/plob_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the price level order book, bound to the top level.
// Depends on price_level_order_book ports only.
module plob_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [199:0] o_m_axis_tdata
);

    // result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped before transaction");

    // one item in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while update in flight");

    // each accepted update produces a result
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |-> ##2 o_m_axis_tvalid)
        else $error("result missing after update");

    // empty bid side reports zero price
    a_bid_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[2] |-> o_m_axis_tdata[66:3] == '0)
        else $error("empty bid side with nonzero level");

endmodule

bind price_level_order_book plob_checker u_plob_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
